>>> hdl/tdps_pkg.sv
// Shared types and constants for the trial-division prime statistics block.
// No dependencies; imported by tdps_rem_unit, the top level and the dv files.
`default_nettype none
package tdps_pkg;

    // Fixed result widths
    localparam int COUNT_BITS = 23;
    localparam int SUM_BITS   = 50;
    localparam int SLOT_BITS  = 4;

    // Parameter defaults
    localparam int VALUE_BITS_DEF = 27;
    localparam int TOP_DEPTH_DEF  = 10;

    // Item kinds
    localparam logic KIND_TEST = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FETCH,
        ST_UPDATE,
        ST_DONE
    } t_state;

    // Status from the remainder unit to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_rem_stat;

endpackage
`default_nettype wire

>>> hdl/tdps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the recent-primes store.
`default_nettype none
module tdps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/tdps_rem_unit.sv
// Iterative remainder unit: restoring division, one quotient bit per cycle.
// Depends on tdps_pkg (status struct).
`default_nettype none
module tdps_rem_unit
    import tdps_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [DIV_BITS-1:0]   i_divisor,
    output t_rem_stat                  o_stat
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [VALUE_BITS-1:0] r_dividend;
    logic [DIV_BITS-1:0]   r_divisor;
    logic [DIV_BITS-1:0]   r_rem;
    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;
    logic [DIV_BITS-1:0]   n_rem;

    // shift in next dividend bit, subtract divisor when it fits
    assign trial = {r_rem, r_dividend[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, r_divisor};
    assign n_rem = (trial >= {1'b0, r_divisor}) ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
            r_divisor  <= i_divisor;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_dividend <= {r_dividend[VALUE_BITS-2:0], 1'b0};
            r_rem      <= n_rem;
        end
    end

    assign o_stat = {r_busy, r_done, (r_rem == '0)};

endmodule
`default_nettype wire

>>> hdl/trial_division_prime_stats.sv
// Trial-division prime statistics: top level with sequencer, stats and store.
// Depends on tdps_pkg, tdps_rem_unit and tdps_ram.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): a transfer carries i_kind,
//    i_candidate_value and i_slot. Kind test checks the candidate for
//    primality; kind read returns one slot of the newest-primes store
//    (slot 0 oldest). o_in_stall is high while an item is in work.
//  - Output channel (o_out_valid / i_out_stall): exactly one result per
//    item, held in an output register. The next item is taken while a
//    finished result still waits; a second result waits in the sequencer
//    until the output register frees up, stalling the input meanwhile.
//  - Item flow: a read item passes the fetch, update and done states into the
//    output register, and the input reopens after that. A test item first
//    tries divisor 2, then each odd divisor k with k*k at most the value on
//    the shared bit-serial remainder unit; composites stop at the first
//    divisor that divides. A prime near 2^27 needs about 5800 odd divisors.
//  - Reset (synchronous, active low) clears the count, the sum, the store
//    fill and pointer, and the handshakes. Store contents are not cleared;
//    the fill count keeps unwritten entries from ever being used.
//  - A stalled receiver holds the output payload stable.
`default_nettype none
module trial_division_prime_stats
    import tdps_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TOP_DEPTH  = TOP_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_kind,
    input  wire logic [VALUE_BITS-1:0] i_candidate_value,
    input  wire logic [SLOT_BITS-1:0]  i_slot,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_is_prime,
    output logic [COUNT_BITS-1:0]      o_prime_count,
    output logic [SUM_BITS-1:0]        o_prime_sum,
    output logic [VALUE_BITS-1:0]      o_slot_value,
    output logic                       o_slot_valid
);

    // divisor and its square
    localparam int KW  = (VALUE_BITS + 1) / 2 + 2;
    localparam int SQW = 2 * KW;
    // store pointers
    localparam int PW  = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
    localparam int FW  = $clog2(TOP_DEPTH + 1);
    localparam int XW  = PW + 1 + SLOT_BITS;   // room for pointer sums

    t_state r_state, n_state;

    // item in work
    logic                  r_kind;
    logic [VALUE_BITS-1:0] r_v;
    logic [SLOT_BITS-1:0]  r_slot;
    logic [KW-1:0]         r_k;
    logic [SQW-1:0]        r_sq;
    logic                  r_prime;
    logic                  r_slot_hit;
    logic [VALUE_BITS-1:0] r_slot_data;

    // running statistics and store bookkeeping
    logic [COUNT_BITS-1:0] r_count;
    logic [SUM_BITS-1:0]   r_sum;
    logic [FW-1:0]         r_fill;
    logic [PW-1:0]         r_oldest;

    // output register
    logic                  r_out_valid;
    logic                  r_o_prime;
    logic [COUNT_BITS-1:0] r_o_count;
    logic [SUM_BITS-1:0]   r_o_sum;
    logic [VALUE_BITS-1:0] r_o_slot_value;
    logic                  r_o_slot_valid;

    // control
    logic      in_take;
    logic      out_free;
    logic      rem_start;
    logic      rd_en;
    logic      wr_en;
    logic      load_out;
    logic      sq_over;
    t_rem_stat rem_stat;

    // address arithmetic
    logic [XW-1:0]         fill_x, old_x, slot_x, depth_x;
    logic [XW-1:0]         newest_raw, slot_raw, tail_raw;
    logic [PW-1:0]         newest_addr, slot_addr, tail_addr, rd_addr, wr_addr;
    logic [PW-1:0]         oldest_inc;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  slot_in_fill;
    logic                  store_take;
    logic [SUM_BITS:0]     sum_add;
    logic [SQW-1:0]        sq_step;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_take  = i_in_valid && !o_in_stall;
    assign sq_over  = r_sq > SQW'(r_v);

    // ---------------- store addressing ----------------
    assign fill_x  = XW'(r_fill);
    assign old_x   = XW'(r_oldest);
    assign slot_x  = XW'(r_slot);
    assign depth_x = XW'(TOP_DEPTH);

    assign newest_raw = old_x + fill_x - XW'(1);
    assign slot_raw   = old_x + slot_x;
    assign tail_raw   = old_x + fill_x;

    // sums that are used stay below twice the depth: one compare and subtract
    // (a slot past the fill may wrap wrong, its data is dropped anyway)
    assign newest_addr = (newest_raw >= depth_x) ? PW'(newest_raw - depth_x) : PW'(newest_raw);
    assign slot_addr   = (slot_raw >= depth_x) ? PW'(slot_raw - depth_x) : PW'(slot_raw);
    assign tail_addr   = (tail_raw >= depth_x) ? PW'(tail_raw - depth_x) : PW'(tail_raw);
    assign oldest_inc  = (old_x + XW'(1) >= depth_x) ? '0 : PW'(old_x + XW'(1));

    assign slot_in_fill = slot_x < fill_x;
    assign rd_addr      = (r_kind == KIND_READ) ? slot_addr : newest_addr;

    // greater than the newest stored prime, or store empty
    assign store_take = (r_fill == '0) || (rd_data < r_v);
    assign wr_addr    = (r_fill == FW'(TOP_DEPTH)) ? r_oldest : tail_addr;

    assign sum_add = {1'b0, r_sum} + (SUM_BITS + 1)'(r_v);
    // (k+2)^2 = k^2 + 4k + 4
    assign sq_step = r_sq + SQW'({r_k, 2'b00}) + SQW'(4);

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == KIND_READ) ? ST_FETCH : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_v < VALUE_BITS'(2)) begin
                    n_state = ST_DONE;
                end else if (sq_over) begin
                    n_state = ST_FETCH;
                end else if (r_k == KW'(2)) begin
                    n_state = r_v[0] ? ST_CHECK : ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_stat.done) begin
                    n_state = rem_stat.zero ? ST_DONE : ST_CHECK;
                end
            end
            ST_FETCH:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: control outputs ----------------
    always_comb begin
        o_in_stall = 1'b1;
        rem_start  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_CHECK:  rem_start  = (r_v >= VALUE_BITS'(2)) && !sq_over && (r_k != KW'(2));
            ST_DIV:    rem_start  = 1'b0;
            ST_FETCH:  rd_en      = 1'b1;
            ST_UPDATE: wr_en      = (r_kind == KIND_TEST) && store_take;
            ST_DONE:   load_out   = out_free;
            default:   o_in_stall = 1'b1;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_UPDATE && r_kind == KIND_TEST) begin
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
                r_sum <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                if (store_take) begin
                    if (r_fill == FW'(TOP_DEPTH)) begin
                        r_oldest <= oldest_inc;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- item datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind     <= i_kind;
            r_v        <= i_candidate_value;
            r_slot     <= i_slot;
            r_k        <= KW'(2);
            r_sq       <= SQW'(4);
            r_prime    <= 1'b0;
            r_slot_hit <= 1'b0;
            r_slot_data <= '0;
        end else begin
            case (r_state)
                ST_CHECK: begin
                    if (r_v >= VALUE_BITS'(2) && !sq_over && r_k == KW'(2)) begin
                        r_k  <= KW'(3);
                        r_sq <= SQW'(9);
                    end
                end
                ST_DIV: begin
                    if (rem_stat.done && !rem_stat.zero) begin
                        r_k  <= r_k + KW'(2);
                        r_sq <= sq_step;
                    end
                end
                ST_FETCH: begin
                    r_prime <= (r_kind == KIND_TEST);
                end
                ST_UPDATE: begin
                    if (r_kind == KIND_READ) begin
                        r_slot_hit  <= slot_in_fill;
                        r_slot_data <= slot_in_fill ? rd_data : '0;
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_prime      <= r_prime;
            r_o_count      <= r_count;
            r_o_sum        <= r_sum;
            r_o_slot_value <= r_slot_data;
            r_o_slot_valid <= r_slot_hit;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_is_prime    = r_o_prime;
    assign o_prime_count = r_o_count;
    assign o_prime_sum   = r_o_sum;
    assign o_slot_value  = r_o_slot_value;
    assign o_slot_valid  = r_o_slot_valid;

    // ---------------- shared remainder unit ----------------
    tdps_rem_unit #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (KW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_v),
        .i_divisor  (r_k),
        .o_stat     (rem_stat)
    );

    // ---------------- newest-primes store ----------------
    tdps_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TOP_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_v),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
`default_nettype wire

>>> dv/prime_stats_checker.sv
`timescale 1ns / 100ps
// Checker for trial_division_prime_stats: follows both channels, predicts every result
// from its own copy of the count, sum and newest-primes store, and compares field by field.
// Depends on tdps_pkg.
module prime_stats_checker
    import tdps_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_kind,
    input  logic [VALUE_BITS_DEF-1:0] i_candidate_value,
    input  logic [SLOT_BITS-1:0]      i_slot,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_is_prime,
    input  logic [COUNT_BITS-1:0]     i_prime_count,
    input  logic [SUM_BITS-1:0]       i_prime_sum,
    input  logic [VALUE_BITS_DEF-1:0] i_slot_value,
    input  logic                      i_slot_valid,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int VBITS       = VALUE_BITS_DEF;
    localparam int DEPTH       = TOP_DEPTH_DEF;
    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic                  prime;
        logic [COUNT_BITS-1:0] count;
        logic [SUM_BITS-1:0]   sum;
        logic [VBITS-1:0]      slot_value;
        logic                  slot_valid;
    } t_prime_result;

    t_prime_result         result_q[$];
    logic [COUNT_BITS-1:0] primes_found;
    logic [SUM_BITS-1:0]   primes_total;
    logic [VBITS-1:0]      newest_primes[DEPTH];
    int                    store_fill;
    int                    store_oldest;
    int                    mismatches;
    int                    checked;

    function automatic logic is_prime_value(logic [VBITS-1:0] v);
        longint unsigned k;
        if (v < 2) begin
            return 1'b0;
        end
        for (k = 2; k * k <= v; k++) begin
            if (v % k == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advances the predicted state by one item and returns its result.
    function automatic t_prime_result predict_item(logic kind, logic [VBITS-1:0] value,
                                                   logic [SLOT_BITS-1:0] slot);
        t_prime_result r;
        logic          admit;
        r = '0;
        if (kind == KIND_TEST) begin
            if (is_prime_value(value)) begin
                r.prime = 1'b1;
                if (primes_found != '1) begin
                    primes_found++;
                end
                if (primes_total > ({SUM_BITS{1'b1}} - value)) begin
                    primes_total = '1;
                end else begin
                    primes_total = primes_total + value;
                end
                // only a prime above the newest stored one enters
                admit = (store_fill == 0) ||
                        (newest_primes[(store_oldest + store_fill - 1) % DEPTH] < value);
                if (admit && store_fill >= DEPTH) begin
                    newest_primes[store_oldest] = value;
                    store_oldest = (store_oldest + 1) % DEPTH;
                end else if (admit) begin
                    newest_primes[(store_oldest + store_fill) % DEPTH] = value;
                    store_fill++;
                end
            end
        end else if (slot < store_fill) begin
            r.slot_value = newest_primes[(store_oldest + slot) % DEPTH];
            r.slot_valid = 1'b1;
        end
        r.count = primes_found;
        r.sum   = primes_total;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t: mismatch on %s at result %0d: got %0d, expected %0d",
                     $time, field, checked, got, want);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_prime_result want;
        if (!i_rst_n) begin
            result_q.delete();
            primes_found = '0;
            primes_total = '0;
            store_fill   = 0;
            store_oldest = 0;
            mismatches   = 0;
            checked      = 0;
        end else begin
            // output side first, so a spurious result is not paired with a same-edge input
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    report_mismatch("transfer with nothing expected", 1, 0);
                end else begin
                    want = result_q.pop_front();
                    if (i_is_prime !== want.prime)
                        report_mismatch("is_prime", i_is_prime, want.prime);
                    if (i_prime_count !== want.count)
                        report_mismatch("prime_count", i_prime_count, want.count);
                    if (i_prime_sum !== want.sum)
                        report_mismatch("prime_sum", i_prime_sum, want.sum);
                    if (i_slot_value !== want.slot_value)
                        report_mismatch("slot_value", i_slot_value, want.slot_value);
                    if (i_slot_valid !== want.slot_valid)
                        report_mismatch("slot_valid", i_slot_valid, want.slot_valid);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                result_q.push_back(predict_item(i_kind, i_candidate_value, i_slot));
            end
        end
        o_fail_count <= mismatches;
        o_checked    <= checked;
        o_pending    <= result_q.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Top of the prime statistics testbench: clock, reset, stimulus and verdict.
// Depends on tdps_pkg, trial_division_prime_stats and prime_stats_checker.
module testbench
    import tdps_pkg::*;
();

    localparam int VBITS        = VALUE_BITS_DEF;
    // Longest quiet stretch of a correct run is the top prime below: about 5800 odd
    // divisors, each through the bit-serial remainder unit. Allow several times that.
    localparam int IDLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DIRECTED     = 24;
    localparam int RANDOM_ITEMS = 1260;
    localparam int TAIL_CYCLES  = 40;
    localparam logic [VBITS-1:0] TOP_PRIME  = 27'd134217689;
    localparam logic [VBITS-1:0] PRIME_SQ   = 27'd1018081;    // 1009 * 1009
    localparam logic [VBITS-1:0] HALF_RANGE = 27'd67108864;   // 2^26

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_kind;
    logic [VBITS-1:0]      i_candidate_value;
    logic [SLOT_BITS-1:0]  i_slot;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_is_prime;
    logic [COUNT_BITS-1:0] o_prime_count;
    logic [SUM_BITS-1:0]   o_prime_sum;
    logic [VBITS-1:0]      o_slot_value;
    logic                  o_slot_valid;

    int fail_count;
    int pending;
    int checked;

    // stimulus bookkeeping
    int sent;
    int n_tests;
    int n_reads;
    int burst_left;
    int hold_asked;
    int hold_given;

    trial_division_prime_stats uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_candidate_value (i_candidate_value),
        .i_slot            (i_slot),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_is_prime        (o_is_prime),
        .o_prime_count     (o_prime_count),
        .o_prime_sum       (o_prime_sum),
        .o_slot_value      (o_slot_value),
        .o_slot_valid      (o_slot_valid)
    );

    prime_stats_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_candidate_value (i_candidate_value),
        .i_slot            (i_slot),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_is_prime        (o_is_prime),
        .i_prime_count     (o_prime_count),
        .i_prime_sum       (o_prime_sum),
        .i_slot_value      (o_slot_value),
        .i_slot_valid      (o_slot_valid),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One input transfer. Drives at the falling edge, returns at the rising edge
    // that takes the item. The sender works in bursts; a new burst may start
    // after a random gap with valid low. The payload holds while stalled.
    task automatic offer(input logic kind, input logic [VBITS-1:0] value,
                         input logic [SLOT_BITS-1:0] slot);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid        <= 1'b1;
        i_kind            <= kind;
        i_candidate_value <= value;
        i_slot            <= slot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        if (kind == KIND_TEST) begin
            n_tests++;
        end else begin
            n_reads++;
        end
        // long receiver hold-offs at two points, while this side keeps offering
        if (sent == 400 || sent == 950) begin
            hold_asked++;
        end
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        logic [VBITS-1:0] climb;
        logic [VBITS-1:0] wide;
        int               pick;
        int               run;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_kind            = KIND_TEST;
        i_candidate_value = '0;
        i_slot            = '0;
        sent              = 0;
        n_tests           = 0;
        n_reads           = 0;
        burst_left        = 0;
        hold_asked        = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-store reads, values below 2, the smallest primes, squares
        // of primes (divisor equal to the root), reads past the fill, primes that
        // are not greater than the newest stored one, and the field extremes.
        offer(KIND_READ, '0, 4'd0);
        offer(KIND_READ, '1, 4'd15);
        offer(KIND_TEST, 27'd0, 4'd0);
        offer(KIND_TEST, 27'd1, 4'd15);
        offer(KIND_TEST, 27'd2, 4'd0);
        offer(KIND_TEST, 27'd3, 4'd0);
        offer(KIND_TEST, 27'd4, 4'd0);
        offer(KIND_TEST, 27'd9, 4'd0);
        offer(KIND_TEST, 27'd25, 4'd0);
        offer(KIND_READ, '0, 4'd0);
        offer(KIND_READ, '0, 4'd1);
        offer(KIND_READ, '0, 4'd2);
        offer(KIND_TEST, 27'd13, 4'd0);
        offer(KIND_TEST, 27'd7, 4'd0);        // smaller than newest: counted, not stored
        offer(KIND_TEST, 27'd13, 4'd0);       // equal to newest: not stored either
        offer(KIND_TEST, '1, 4'd0);           // widest candidate, composite
        offer(KIND_TEST, PRIME_SQ, 4'd0);
        offer(KIND_TEST, HALF_RANGE, 4'd0);
        for (int s = 0; s < 4; s++) begin
            offer(KIND_READ, '1, SLOT_BITS'(s));
        end
        offer(KIND_READ, '0, 4'd9);
        offer(KIND_READ, '0, 4'd10);

        // Random part. Mostly climbing runs of candidates so that new primes keep
        // entering the store and rolling it, each run followed by read-backs.
        // The rest: small noise (mostly not greater than the newest stored prime), wide composites that leave
        // early but toggle every candidate bit, and reads of any slot.
        climb = 27'd14;
        while (sent < DIRECTED + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                run = $urandom_range(3, 12);
                repeat (run) begin
                    climb = climb + VBITS'($urandom_range(1, 16));
                    offer(KIND_TEST, climb, SLOT_BITS'($urandom));
                end
                run = $urandom_range(1, 4);
                repeat (run) offer(KIND_READ, VBITS'($urandom),
                                   SLOT_BITS'($urandom_range(0, 9)));
            end else if (pick < 50) begin
                offer(KIND_TEST, VBITS'($urandom_range(0, 1023)), SLOT_BITS'($urandom));
            end else if (pick < 70) begin
                if ($urandom_range(0, 1) == 1) begin
                    wide = VBITS'(3 * $urandom_range(0, 44739242));
                end else begin
                    wide    = VBITS'($urandom);
                    wide[0] = 1'b0;
                end
                offer(KIND_TEST, wide, SLOT_BITS'($urandom));
            end else begin
                offer(KIND_READ, VBITS'($urandom), SLOT_BITS'($urandom_range(0, 15)));
            end
        end

        // Closing: one prime near the top of the range (the slowest item), then a
        // read of every slot value including those past the store depth.
        offer(KIND_TEST, TOP_PRIME, 4'd0);
        for (int s = 0; s < 16; s++) begin
            offer(KIND_READ, VBITS'($urandom), SLOT_BITS'(s));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d transfers in: %0d primality tests, %0d store reads, %0d checked.",
                 sent, n_tests, n_reads, checked);
        $display("Included 0 and 1, prime squares, the widest candidate, a near-top prime %s",
                 "and a store rolled well past its depth.");
        if (fail_count == 0 && pending == 0) begin
            $display("trial_division_prime_stats test passed");
        end else begin
            $display("trial_division_prime_stats test failed");
        end
        $finish;
    end

    // Receiver: stall pattern of its own, switching mode after each random-length segment,
    // with stretches of no stall. On request it holds off for a long, counted
    // stretch so the block fills and stalls its input.
    initial begin : receiver
        t_stall_mode mode;
        int          seg;
        i_out_stall = 1'b0;
        hold_given  = 0;
        forever begin
            seg  = $urandom_range(8, 60);
            mode = t_stall_mode'($urandom_range(0, 3));
            repeat (seg) begin
                @(negedge i_clk);
                if (hold_given < hold_asked) begin
                    hold_given++;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    STALL_NONE: begin
                        i_out_stall <= 1'b0;
                    end
                    STALL_LIGHT: begin
                        i_out_stall <= ($urandom_range(0, 3) == 0);
                    end
                    STALL_HEAVY: begin
                        i_out_stall <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        i_out_stall <= ~i_out_stall;
                    end
                endcase
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
                 IDLE_LIMIT, pending);
        $display("trial_division_prime_stats test failed");
        $finish;
    end

endmodule

>>> files.f
hdl/tdps_pkg.sv
hdl/tdps_ram.sv
hdl/tdps_rem_unit.sv
hdl/trial_division_prime_stats.sv
dv/prime_stats_checker.sv
dv/testbench.sv
